/* rtl/cle_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the circular list cursor engine.
// Used by every file of the block; depends on nothing.
package cle_pkg;

  // Default node store depth
  localparam int unsigned CAPACITY = 256;

  // Fixed payload widths
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 9;

  // Command codes of a request
  typedef enum logic [CMD_W-1:0] {
    CMD_ADD     = 2'd0,
    CMD_REMOVE  = 2'd1,
    CMD_ADVANCE = 2'd2
  } cmd_e;

  // Status codes of a result
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_LINK,
    S_REMOVE,
    S_ADVANCE,
    S_DONE
  } state_e;

  // Write enables of the node store
  typedef struct packed {
    logic link_we;
    logic val_we;
  } node_we_t;

  // Free stack commands
  typedef struct packed {
    logic pop;
    logic push;
  } fs_ctl_t;

endpackage

/* rtl/cle_if.sv */
`timescale 1ns / 1ps
// Request and result channels of the circular list cursor engine.
// Depends on cle_pkg for the payload widths.
interface cle_req_if;
  logic                                valid;
  logic                                ready;
  logic [cle_pkg::CMD_W-1:0]           command;
  logic signed [cle_pkg::DATA_W-1:0]   item_value;

  modport source (output valid, output command, output item_value, input ready);
  modport sink   (input valid, input command, input item_value, output ready);
endinterface

interface cle_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [cle_pkg::DATA_W-1:0]   removed_value;
  logic [cle_pkg::STATUS_W-1:0]        status;
  logic signed [cle_pkg::DATA_W-1:0]   cursor_value;
  logic [cle_pkg::COUNT_W-1:0]         node_count;

  modport source (output valid, output removed_value, output status,
                  output cursor_value, output node_count, input ready);
  modport sink   (input valid, input removed_value, input status,
                  input cursor_value, input node_count, output ready);
endinterface

/* rtl/circular_list_cursor_engine_top.sv */
`timescale 1ns / 1ps
// Top level of the circular list cursor engine: channels, sequencer, node store, free stack.
// Depends on cle_pkg, cle_if, cle_ctrl, cle_node_store and cle_free_stack.

// A circular singly linked list with a cursor, kept in a node store of CAPACITY
// entries (value and link memories) and a free index stack in a third memory.
// One request is worked on at a time. A request is taken in the idle state; an
// add to a nonempty list passes the read, link and done states, remove and
// advance pass read, their own state and done, add on an empty list read and
// done, and rejected or unused commands go straight to done. These steps follow
// from the registered reads of the memories and the single write port of the
// link memory, which an add must use twice. The result sits in an output
// register, so a new request is taken while it waits; the following result is
// held back until the register is emptied. No clearing pass is needed after
// reset: free stack slots never written are recognized by a low-water mark.
module circular_list_cursor_engine_top #(
  parameter int unsigned CAPACITY = cle_pkg::CAPACITY
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  cle_req_if.sink      req_i,
  cle_rsp_if.source    rsp_o
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  cle_pkg::node_we_t          node_we;
  cle_pkg::fs_ctl_t           fs_ctl;
  logic [IW-1:0]              link_raddr;
  logic [IW-1:0]              link_waddr;
  logic [IW-1:0]              link_wdata;
  logic [IW-1:0]              val_raddr;
  logic [IW-1:0]              val_waddr;
  logic [cle_pkg::DATA_W-1:0] val_wdata;
  logic [IW-1:0]              link_rdata;
  logic [cle_pkg::DATA_W-1:0] val_rdata;
  logic [IW-1:0]              push_idx;
  logic [IW-1:0]              fresh_idx;
  logic [CW-1:0]              free_cnt;

  cle_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .rsp_o        (rsp_o),
    .node_we_o    (node_we),
    .link_raddr_o (link_raddr),
    .link_waddr_o (link_waddr),
    .link_wdata_o (link_wdata),
    .val_raddr_o  (val_raddr),
    .val_waddr_o  (val_waddr),
    .val_wdata_o  (val_wdata),
    .link_rdata_i (link_rdata),
    .val_rdata_i  (val_rdata),
    .fs_ctl_o     (fs_ctl),
    .push_idx_o   (push_idx),
    .fresh_i      (fresh_idx),
    .free_cnt_i   (free_cnt)
  );

  cle_node_store #(
    .CAPACITY (CAPACITY)
  ) u_node_store (
    .clk_i        (clk_i),
    .we_i         (node_we),
    .link_raddr_i (link_raddr),
    .link_waddr_i (link_waddr),
    .link_wdata_i (link_wdata),
    .val_raddr_i  (val_raddr),
    .val_waddr_i  (val_waddr),
    .val_wdata_i  (val_wdata),
    .link_rdata_o (link_rdata),
    .val_rdata_o  (val_rdata)
  );

  cle_free_stack #(
    .CAPACITY (CAPACITY)
  ) u_free_stack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (fs_ctl),
    .push_idx_i (push_idx),
    .fresh_o    (fresh_idx),
    .free_cnt_o (free_cnt)
  );

endmodule

/* rtl/cle_node_store.sv */
`timescale 1ns / 1ps
// Node store: value memory and link memory, one write and one registered read each.
// Depends on cle_pkg for node_we_t and the data width.
module cle_node_store #(
  parameter int unsigned CAPACITY = cle_pkg::CAPACITY
) (
  input  logic                              clk_i,
  input  cle_pkg::node_we_t                 we_i,
  input  logic [$clog2(CAPACITY)-1:0]       link_raddr_i,
  input  logic [$clog2(CAPACITY)-1:0]       link_waddr_i,
  input  logic [$clog2(CAPACITY)-1:0]       link_wdata_i,
  input  logic [$clog2(CAPACITY)-1:0]       val_raddr_i,
  input  logic [$clog2(CAPACITY)-1:0]       val_waddr_i,
  input  logic [cle_pkg::DATA_W-1:0]        val_wdata_i,
  output logic [$clog2(CAPACITY)-1:0]       link_rdata_o,
  output logic [cle_pkg::DATA_W-1:0]        val_rdata_o
);

  localparam int unsigned IW = $clog2(CAPACITY);

  logic [IW-1:0]              link_mem [CAPACITY];
  logic [cle_pkg::DATA_W-1:0] val_mem  [CAPACITY];

  // Link memory: write, then registered read
  always_ff @(posedge clk_i) begin
    if (we_i.link_we) begin
      link_mem[link_waddr_i] <= link_wdata_i;
    end
    link_rdata_o <= link_mem[link_raddr_i];
  end

  // Value memory: write, then registered read
  always_ff @(posedge clk_i) begin
    if (we_i.val_we) begin
      val_mem[val_waddr_i] <= val_wdata_i;
    end
    val_rdata_o <= val_mem[val_raddr_i];
  end

endmodule

/* rtl/cle_free_stack.sv */
`timescale 1ns / 1ps
// Free index stack in a synchronous memory, with a low-water mark in place of a fill.
// Depends on cle_pkg for fs_ctl_t.
module cle_free_stack #(
  parameter int unsigned CAPACITY = cle_pkg::CAPACITY
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  cle_pkg::fs_ctl_t                    ctl_i,
  input  logic [$clog2(CAPACITY)-1:0]         push_idx_i,
  output logic [$clog2(CAPACITY)-1:0]         fresh_o,
  output logic [$clog2(CAPACITY+1)-1:0]       free_cnt_o
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [IW-1:0] stack_mem [CAPACITY];
  logic [IW-1:0] rd_data_q;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] below_top;
  logic [CW-1:0] top_q, top_d;
  logic [CW-1:0] low_q, low_d;

  // Slot under the top; an entry below the low-water mark was never written and holds its own index
  assign below_top = IW'(top_q - CW'(1));
  assign rd_addr   = (top_q == '0) ? '0 : below_top;
  assign fresh_o   = (top_q == low_q) ? below_top : rd_data_q;
  assign free_cnt_o = top_q;

  // Pop lowers the top and drags the mark along; push raises the top
  always_comb begin
    top_d = top_q;
    low_d = low_q;
    if (ctl_i.pop && top_q != '0) begin
      top_d = top_q - CW'(1);
      if (top_q == low_q) begin
        low_d = top_q - CW'(1);
      end
    end else if (ctl_i.push && top_q != CW'(CAPACITY)) begin
      top_d = top_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= CW'(CAPACITY);
      low_q <= CW'(CAPACITY);
    end else begin
      top_q <= top_d;
      low_q <= low_d;
    end
  end

  // Stack memory: push writes at the top, read the slot under it every cycle
  always_ff @(posedge clk_i) begin
    if (ctl_i.push && !ctl_i.pop && top_q != CW'(CAPACITY)) begin
      stack_mem[IW'(top_q)] <= push_idx_i;
    end
    rd_data_q <= stack_mem[rd_addr];
  end

`ifndef NO_ASSERTIONS
  a_low_below_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    low_q <= top_q)
    else $error("free stack low-water mark above top");
  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.pop |-> top_q != '0)
    else $error("pop from empty free stack");
  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.push |-> top_q != CW'(CAPACITY) && !ctl_i.pop)
    else $error("push into full free stack");
`endif

endmodule

/* rtl/cle_ctrl.sv */
`timescale 1ns / 1ps
// Command sequencer: cursor registers, read-modify-write of the stores, result register.
// Depends on cle_pkg and the cle_req_if / cle_rsp_if channels.
module cle_ctrl #(
  parameter int unsigned CAPACITY = cle_pkg::CAPACITY
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  cle_req_if.sink                             req_i,
  cle_rsp_if.source                           rsp_o,
  output cle_pkg::node_we_t                   node_we_o,
  output logic [$clog2(CAPACITY)-1:0]         link_raddr_o,
  output logic [$clog2(CAPACITY)-1:0]         link_waddr_o,
  output logic [$clog2(CAPACITY)-1:0]         link_wdata_o,
  output logic [$clog2(CAPACITY)-1:0]         val_raddr_o,
  output logic [$clog2(CAPACITY)-1:0]         val_waddr_o,
  output logic [cle_pkg::DATA_W-1:0]          val_wdata_o,
  input  logic [$clog2(CAPACITY)-1:0]         link_rdata_i,
  input  logic [cle_pkg::DATA_W-1:0]          val_rdata_i,
  output cle_pkg::fs_ctl_t                    fs_ctl_o,
  output logic [$clog2(CAPACITY)-1:0]         push_idx_o,
  input  logic [$clog2(CAPACITY)-1:0]         fresh_i,
  input  logic [$clog2(CAPACITY+1)-1:0]       free_cnt_i
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned DW = cle_pkg::DATA_W;

  cle_pkg::state_e state_q, state_d;

  logic [cle_pkg::CMD_W-1:0]    cmd_q, cmd_d;
  logic [DW-1:0]                item_q, item_d;
  logic [IW-1:0]                cur_q, cur_d;
  logic [DW-1:0]                cur_val_q, cur_val_d;
  logic [CW-1:0]                size_q, size_d;
  logic [IW-1:0]                idx_q, idx_d;
  logic [DW-1:0]                res_removed_q, res_removed_d;
  logic [cle_pkg::STATUS_W-1:0] res_status_q, res_status_d;

  logic                         out_valid_q;
  logic signed [DW-1:0]         out_removed_q;
  logic [cle_pkg::STATUS_W-1:0] out_status_q;
  logic signed [DW-1:0]         out_cursor_q;
  logic [cle_pkg::COUNT_W-1:0]  out_count_q;

  logic accept;
  logic slot_free;
  logic list_empty;
  logic store_full;

  assign req_i.ready = (state_q == cle_pkg::S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign slot_free   = !out_valid_q || rsp_o.ready;
  assign list_empty  = (size_q == '0);
  assign store_full  = (free_cnt_i == '0);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cle_pkg::S_IDLE: begin
        if (accept) begin
          case (req_i.command) inside
            cle_pkg::CMD_ADD: begin
              state_d = store_full ? cle_pkg::S_DONE : cle_pkg::S_READ;
            end
            cle_pkg::CMD_REMOVE, cle_pkg::CMD_ADVANCE: begin
              state_d = list_empty ? cle_pkg::S_DONE : cle_pkg::S_READ;
            end
            default: begin
              state_d = cle_pkg::S_DONE;
            end
          endcase
        end
      end
      cle_pkg::S_READ: begin
        case (cmd_q)
          cle_pkg::CMD_ADD:     state_d = list_empty ? cle_pkg::S_DONE : cle_pkg::S_LINK;
          cle_pkg::CMD_REMOVE:  state_d = cle_pkg::S_REMOVE;
          cle_pkg::CMD_ADVANCE: state_d = cle_pkg::S_ADVANCE;
          default:              state_d = cle_pkg::S_DONE;
        endcase
      end
      cle_pkg::S_LINK, cle_pkg::S_REMOVE, cle_pkg::S_ADVANCE: begin
        state_d = cle_pkg::S_DONE;
      end
      cle_pkg::S_DONE: begin
        if (slot_free) begin
          state_d = cle_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = cle_pkg::S_IDLE;
      end
    endcase
  end

  // Memory accesses and register updates per state
  always_comb begin
    cmd_d         = cmd_q;
    item_d        = item_q;
    cur_d         = cur_q;
    cur_val_d     = cur_val_q;
    size_d        = size_q;
    idx_d         = idx_q;
    res_removed_d = res_removed_q;
    res_status_d  = res_status_q;
    node_we_o     = '0;
    fs_ctl_o      = '0;
    link_raddr_o  = (state_q == cle_pkg::S_READ) ? link_rdata_i : cur_q;
    val_raddr_o   = link_rdata_i;
    link_waddr_o  = cur_q;
    link_wdata_o  = idx_q;
    val_waddr_o   = fresh_i;
    val_wdata_o   = item_q;
    push_idx_o    = idx_q;
    unique case (state_q)
      cle_pkg::S_IDLE: begin
        // Latch the request and settle early rejects
        if (accept) begin
          cmd_d         = req_i.command;
          item_d        = req_i.item_value;
          res_removed_d = '0;
          res_status_d  = cle_pkg::ST_OK;
          case (req_i.command) inside
            cle_pkg::CMD_ADD: begin
              if (store_full) res_status_d = cle_pkg::ST_FULL;
            end
            cle_pkg::CMD_REMOVE, cle_pkg::CMD_ADVANCE: begin
              if (list_empty) res_status_d = cle_pkg::ST_EMPTY;
            end
            default: begin
              res_status_d = cle_pkg::ST_OK;
            end
          endcase
        end
      end
      cle_pkg::S_READ: begin
        case (cmd_q)
          cle_pkg::CMD_ADD: begin
            // Allocate a node and point it past the cursor, or at itself
            node_we_o.val_we  = 1'b1;
            node_we_o.link_we = 1'b1;
            link_waddr_o      = fresh_i;
            link_wdata_o      = list_empty ? fresh_i : link_rdata_i;
            fs_ctl_o.pop      = 1'b1;
            size_d            = size_q + CW'(1);
            idx_d             = fresh_i;
            if (list_empty) begin
              cur_d     = fresh_i;
              cur_val_d = item_q;
            end
          end
          default: begin
            // Hold the successor of the cursor; its entry is read now
            idx_d = link_rdata_i;
          end
        endcase
      end
      cle_pkg::S_LINK: begin
        // Hook the new node behind the cursor
        node_we_o.link_we = 1'b1;
      end
      cle_pkg::S_REMOVE: begin
        // Unlink the victim and return its index to the free stack
        res_removed_d = val_rdata_i;
        if (idx_q == cur_q) begin
          size_d = '0;
        end else begin
          node_we_o.link_we = 1'b1;
          link_wdata_o      = link_rdata_i;
          size_d            = size_q - CW'(1);
        end
        fs_ctl_o.push = (free_cnt_i != CW'(CAPACITY));
      end
      cle_pkg::S_ADVANCE: begin
        cur_d     = idx_q;
        cur_val_d = val_rdata_i;
      end
      cle_pkg::S_DONE: begin
        // Result is loaded by the output register
      end
      default: begin
        cur_d = cur_q;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cle_pkg::S_IDLE;
      cur_q       <= '0;
      size_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      size_q  <= size_d;
      if (state_q == cle_pkg::S_DONE && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q         <= cmd_d;
    item_q        <= item_d;
    cur_val_q     <= cur_val_d;
    idx_q         <= idx_d;
    res_removed_q <= res_removed_d;
    res_status_q  <= res_status_d;
    if (state_q == cle_pkg::S_DONE && slot_free) begin
      out_removed_q <= res_removed_q;
      out_status_q  <= res_status_q;
      out_cursor_q  <= list_empty ? '0 : cur_val_q;
      out_count_q   <= cle_pkg::COUNT_W'(size_q);
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.removed_value = out_removed_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.cursor_value  = out_cursor_q;
  assign rsp_o.node_count    = out_count_q;

`ifndef NO_ASSERTIONS
  a_nodes_conserved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CW+1)'(size_q) + (CW+1)'(free_cnt_i) == (CW+1)'(CAPACITY))
    else $error("list size and free count do not add up to capacity");
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == cle_pkg::S_IDLE |-> !node_we_o.link_we && !node_we_o.val_we
                                   && !fs_ctl_o.pop && !fs_ctl_o.push)
    else $error("store written while no request is in flight");
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status == cle_pkg::ST_FULL
      |-> rsp_o.node_count == cle_pkg::COUNT_W'(CAPACITY))
    else $error("store full reported below capacity");
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status == cle_pkg::ST_EMPTY
      |-> rsp_o.node_count == '0 && rsp_o.cursor_value == '0
          && rsp_o.removed_value == '0)
    else $error("empty status with a nonempty result");
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> $past(state_q) == cle_pkg::S_DONE)
    else $error("result raised outside the completion state");
`endif

endmodule

/* verif/circular_list_cursor_engine_top_tb.sv */
`timescale 1ns / 1ps
// Testbench of the circular list cursor engine: directed and random request streams.
// Depends on cle_pkg, cle_if and the circular_list_cursor_engine_top RTL.
module circular_list_cursor_engine_top_tb;

  localparam int unsigned CLK_PERIOD  = 4;
  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned IDLE_PCT    = 16;
  localparam int unsigned ITEM_TARGET = 1450;
  localparam int unsigned DRAIN_LIMIT = 1000;
  localparam int unsigned SETTLE_CYCLES = 16;
  // Command code outside the defined set; the block ignores it
  localparam logic [cle_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  // One expected result of the list engine
  typedef struct {
    logic signed [cle_pkg::DATA_W-1:0]  removed_value;
    cle_pkg::status_e                   status;
    logic signed [cle_pkg::DATA_W-1:0]  cursor_value;
    logic [cle_pkg::COUNT_W-1:0]        node_count;
  } list_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  cle_req_if req_if ();
  cle_rsp_if rsp_if ();

  circular_list_cursor_engine_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Shadow copy of the list held by the block
  logic [cle_pkg::DATA_W-1:0] node_val   [cle_pkg::CAPACITY];
  logic [7:0]                 node_link  [cle_pkg::CAPACITY];
  logic [7:0]                 free_stack [cle_pkg::CAPACITY];
  int unsigned                free_top;
  logic [7:0]                 cursor_idx;
  int unsigned                list_size;

  list_result_t pending_results[$];
  int unsigned  error_count;
  int unsigned  requests_sent;
  int unsigned  results_checked;
  int unsigned  full_rejects;
  int unsigned  empty_hits;
  bit           stall_en;

  // Compute the result of one request and advance the shadow list
  function automatic list_result_t list_step(logic [cle_pkg::CMD_W-1:0] cmd,
                                             logic [cle_pkg::DATA_W-1:0] val);
    list_result_t r;
    logic [7:0]   cur;
    logic [7:0]   fresh;
    logic [7:0]   victim;
    cur = cursor_idx;
    r.removed_value = '0;
    r.status = cle_pkg::ST_OK;
    case (cmd)
      cle_pkg::CMD_ADD: begin
        if (free_top == 0) begin
          r.status = cle_pkg::ST_FULL;
        end else begin
          free_top--;
          fresh = free_stack[free_top];
          node_val[fresh] = val;
          if (list_size == 0) begin
            node_link[fresh] = fresh;
            cursor_idx = fresh;
          end else begin
            node_link[fresh] = node_link[cur];
            node_link[cur] = fresh;
          end
          list_size++;
        end
      end
      cle_pkg::CMD_REMOVE: begin
        if (list_size == 0) begin
          r.status = cle_pkg::ST_EMPTY;
        end else begin
          victim = node_link[cur];
          r.removed_value = node_val[victim];
          // Unlink the node after the cursor; a lone node empties the list
          if (victim == cur) begin
            list_size = 0;
          end else begin
            node_link[cur] = node_link[victim];
            list_size--;
          end
          if (free_top < cle_pkg::CAPACITY) begin
            free_stack[free_top] = victim;
            free_top++;
          end
        end
      end
      cle_pkg::CMD_ADVANCE: begin
        if (list_size == 0) r.status = cle_pkg::ST_EMPTY;
        else cursor_idx = node_link[cur];
      end
      default: ;
    endcase
    r.cursor_value = (list_size == 0) ? '0 : node_val[cursor_idx];
    r.node_count = list_size[cle_pkg::COUNT_W-1:0];
    return r;
  endfunction

  // Mix extreme values into random data
  function automatic logic [cle_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Drive one request, hold it until accepted and record its expected result
  task automatic send_request(logic [cle_pkg::CMD_W-1:0] cmd,
                              logic [cle_pkg::DATA_W-1:0] val);
    list_result_t r;
    if (stall_en && $urandom_range(99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < IDLE_PCT);
    end
    req_if.valid      <= 1'b1;
    req_if.command    <= cmd;
    req_if.item_value <= val;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    r = list_step(cmd, val);
    if (r.status == cle_pkg::ST_FULL) full_rejects++;
    if (r.status == cle_pkg::ST_EMPTY) empty_hits++;
    pending_results.push_back(r);
    requests_sent++;
    @(negedge clk_i);
  endtask

  // Randomly stall the result channel
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rsp_if.ready <= !stall_en || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    list_result_t exp_r;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("result arrived with no request outstanding");
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        results_checked++;
        if (rsp_if.removed_value !== exp_r.removed_value) begin
          $error("removed_value: expected %0d, got %0d", exp_r.removed_value,
                 rsp_if.removed_value);
          error_count++;
        end
        if (rsp_if.status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, rsp_if.status);
          error_count++;
        end
        if (rsp_if.cursor_value !== exp_r.cursor_value) begin
          $error("cursor_value: expected %0d, got %0d", exp_r.cursor_value,
                 rsp_if.cursor_value);
          error_count++;
        end
        if (rsp_if.node_count !== exp_r.node_count) begin
          $error("node_count: expected %0d, got %0d", exp_r.node_count,
                 rsp_if.node_count);
          error_count++;
        end
      end
    end
  end

  // Remove, advance and an unused command on an empty list
  task automatic test_empty_list();
    send_request(cle_pkg::CMD_REMOVE, $urandom);
    send_request(cle_pkg::CMD_ADVANCE, $urandom);
    send_request(CMD_UNUSED, $urandom);
  endtask

  // Self-linked single node, extreme values, removal of the last node
  task automatic test_edge_values();
    send_request(cle_pkg::CMD_ADD, 32'h8000_0000);
    send_request(cle_pkg::CMD_ADVANCE, 32'h7FFF_FFFF);
    send_request(cle_pkg::CMD_ADD, 32'h7FFF_FFFF);
    send_request(cle_pkg::CMD_ADD, 32'h0000_0000);
    send_request(cle_pkg::CMD_ADVANCE, 32'h0000_0000);
    send_request(cle_pkg::CMD_ADVANCE, 32'hFFFF_FFFF);
    send_request(CMD_UNUSED, 32'hFFFF_FFFF);
    send_request(cle_pkg::CMD_REMOVE, 32'h5555_5555);
    send_request(cle_pkg::CMD_ADD, 32'h5555_5555);
    send_request(cle_pkg::CMD_ADD, 32'hAAAA_AAAA);
    send_request(cle_pkg::CMD_ADVANCE, 32'hAAAA_AAAA);
    send_request(cle_pkg::CMD_REMOVE, 32'h0000_0000);
    send_request(cle_pkg::CMD_REMOVE, 32'hFFFF_FFFF);
    send_request(cle_pkg::CMD_REMOVE, 32'h8000_0000);
    send_request(cle_pkg::CMD_REMOVE, 32'h7FFF_FFFF);
  endtask

  // Fill the store to the brim back to back, hit full, then drain it with random stalls
  task automatic test_full_store();
    int unsigned r;
    stall_en = 1'b0;
    while (list_size < cle_pkg::CAPACITY) begin
      r = $urandom_range(99);
      if (r < 80) send_request(cle_pkg::CMD_ADD, pick_value());
      else if (r < 92) send_request(cle_pkg::CMD_ADVANCE, $urandom);
      else send_request(cle_pkg::CMD_REMOVE, $urandom);
    end
    send_request(cle_pkg::CMD_ADD, pick_value());
    send_request(cle_pkg::CMD_ADD, pick_value());
    send_request(cle_pkg::CMD_ADVANCE, $urandom);
    send_request(CMD_UNUSED, $urandom);
    send_request(cle_pkg::CMD_ADD, pick_value());
    stall_en = 1'b1;
    while (list_size > 0) begin
      r = $urandom_range(99);
      if (r < 80) send_request(cle_pkg::CMD_REMOVE, $urandom);
      else if (r < 92) send_request(cle_pkg::CMD_ADVANCE, $urandom);
      else send_request(cle_pkg::CMD_ADD, pick_value());
    end
    send_request(cle_pkg::CMD_REMOVE, $urandom);
  endtask

  // Random mix of all commands, keeping the list mostly short
  task automatic test_random_mix();
    int unsigned r;
    int unsigned add_w;
    while (requests_sent < ITEM_TARGET) begin
      add_w = (list_size < 8) ? 50 : ((list_size > 48) ? 25 : 38);
      r = $urandom_range(99);
      if (r < 5) send_request(CMD_UNUSED, $urandom);
      else if (r < 5 + add_w) send_request(cle_pkg::CMD_ADD, pick_value());
      else if (r < 5 + add_w + (95 - add_w) / 2) send_request(cle_pkg::CMD_REMOVE, $urandom);
      else send_request(cle_pkg::CMD_ADVANCE, $urandom);
    end
  endtask

  // Hold off until every result is back, then let the block settle
  task automatic wait_drained();
    int unsigned waited;
    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk_i);
      waited++;
    end
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      error_count++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    for (int i = 0; i < cle_pkg::CAPACITY; i++) free_stack[i] = i[7:0];
    free_top = cle_pkg::CAPACITY;
    cursor_idx = '0;
    list_size = 0;
    error_count = 0;
    requests_sent = 0;
    results_checked = 0;
    full_rejects = 0;
    empty_hits = 0;
    stall_en = 1'b1;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.command = cle_pkg::CMD_ADD;
    req_if.item_value = '0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_empty_list();
    test_edge_values();
    test_full_store();
    test_random_mix();
    req_if.valid <= 1'b0;
    wait_drained();

    $display("Sent %0d requests and checked %0d results: %0d full-store rejects,",
             requests_sent, results_checked, full_rejects);
    $display("%0d empty-list responses, one complete fill and drain of the store.",
             empty_hits);
    if (error_count == 0) begin
      $display("circular_list_cursor_engine_top_tb passed");
    end else begin
      $display("circular_list_cursor_engine_top_tb failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2_000_000;
    $display("circular_list_cursor_engine_top_tb failed");
    $finish;
  end

endmodule
